// ----- rtl/core/line_centroid_offset_assert.svh -----
// ----------------------------------------------------------------------------
// line centroid offset assertion macros
// concurrent checks used by the top level, empty when synthesising
// ----------------------------------------------------------------------------
`ifndef LINE_CENTROID_OFFSET_ASSERT_SVH
`define LINE_CENTROID_OFFSET_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LCO_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line_centroid_offset: same-cycle check failed");

// next-cycle implication
`define LCO_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line_centroid_offset: next-cycle check failed");

`else

`define LCO_ASSERT_NOW(label, clk, rst, ante, cons)
`define LCO_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/lco_pkg.sv -----
// ----------------------------------------------------------------------------
// lco_pkg
// widths, position weights, divider item type and darkness helpers
// ----------------------------------------------------------------------------
package lco_pkg;

   localparam int CHANNELS       = 8;
   localparam int PAIRS          = CHANNELS / 2;
   localparam int LEVEL_W        = 12;
   localparam int ADC_MAX        = 4095;
   localparam int DARK_W         = $clog2(ADC_MAX + 1);
   localparam int CALC_W         = ((DARK_W > LEVEL_W) ? DARK_W : LEVEL_W) + 1;
   localparam int TOT_W          = DARK_W + $clog2(CHANNELS);
   // sum of the positive weights bounds the weighted sum magnitude
   localparam int WEIGHT_POS_SUM = 800;
   localparam int MAG_W          = DARK_W + $clog2(WEIGHT_POS_SUM + 1);
   localparam int WSUM_W         = MAG_W + 1;
   localparam int OFFSET_LIMIT   = 350;
   localparam int QUOT_W         = $clog2(OFFSET_LIMIT + 1);
   localparam int OFFSET_W       = 10;
   localparam int FRONT_STAGES   = 4;
   localparam int DIV_STAGES     = QUOT_W;
   localparam int PIPE_STAGES    = FRONT_STAGES + DIV_STAGES;

   localparam int POS_WEIGHT [CHANNELS] = '{-350, -250, -150, -50, 50, 150, 250, 350};

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [DARK_W-1:0]  dark_type;

   // one item in flight through the divider
   typedef struct packed {
      logic [TOT_W-1:0]  rem;
      logic [QUOT_W-1:0] low;
      logic [QUOT_W-1:0] quot;
      logic [TOT_W-1:0]  den;
      logic              neg;
      logic              white;
   } div_type;

   // full scale minus level, saturating at zero
   function automatic dark_type dark_of(input level_type level);
      logic [CALC_W-1:0] diff;
      diff = CALC_W'(ADC_MAX) - CALC_W'(level);
      if (diff[CALC_W-1]) begin
         return '0;
      end
      return diff[DARK_W-1:0];
   endfunction

   // darkness times the channel's position weight
   function automatic logic signed [WSUM_W-1:0] weigh(input int idx, input dark_type dark);
      int prod;
      prod = POS_WEIGHT[idx] * int'(dark);
      return WSUM_W'(prod);
   endfunction

endpackage

// ----- rtl/core/lco_dark_sum.sv -----
// ----------------------------------------------------------------------------
// lco_dark_sum
// front stages: darkness, pair sums, totals, sign and magnitude split
// ----------------------------------------------------------------------------
module lco_dark_sum
   import lco_pkg::*;
(
   input  logic                    clock,
   input  logic [FRONT_STAGES-1:0] enable,
   input  level_type               level [CHANNELS],
   output div_type                 div_out
);

   dark_type                  dark_ff   [CHANNELS];
   logic signed [WSUM_W-1:0]  pair_w_ff [PAIRS];
   logic [TOT_W-1:0]          pair_t_ff [PAIRS];
   logic signed [WSUM_W-1:0]  wsum_ff;
   logic signed [WSUM_W-1:0]  wsum_in;
   logic [TOT_W-1:0]          tsum_ff;
   logic [TOT_W-1:0]          tsum_in;
   logic [MAG_W-1:0]          mag;
   div_type                   div_ff;
   div_type                   div_in;

   // stage one: darkness per channel
   always_ff @(posedge clock) begin
      if (enable[0]) begin
         for (int i = 0; i < CHANNELS; i++) begin
            dark_ff[i] <= dark_of(level[i]);
         end
      end
   end

   // stage two: weighted and plain sums of neighbouring channels
   always_ff @(posedge clock) begin
      if (enable[1]) begin
         for (int j = 0; j < PAIRS; j++) begin
            pair_w_ff[j] <= weigh(2 * j, dark_ff[2 * j]) + weigh(2 * j + 1, dark_ff[2 * j + 1]);
            pair_t_ff[j] <= TOT_W'(dark_ff[2 * j]) + TOT_W'(dark_ff[2 * j + 1]);
         end
      end
   end

   // stage three: whole-frame sums
   always_comb begin
      wsum_in = '0;
      tsum_in = '0;
      for (int j = 0; j < PAIRS; j++) begin
         wsum_in = wsum_in + pair_w_ff[j];
         tsum_in = tsum_in + pair_t_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (enable[2]) begin
         wsum_ff <= wsum_in;
         tsum_ff <= tsum_in;
      end
   end

   // stage four: magnitude; top bits seed the remainder, the rest shift in
   always_comb begin
      mag          = wsum_ff[WSUM_W-1] ? MAG_W'(-wsum_ff) : MAG_W'(wsum_ff);
      div_in.rem   = TOT_W'(mag >> QUOT_W);
      div_in.low   = mag[QUOT_W-1:0];
      div_in.quot  = '0;
      div_in.den   = tsum_ff;
      div_in.neg   = wsum_ff[WSUM_W-1];
      div_in.white = (tsum_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (enable[3]) begin
         div_ff <= div_in;
      end
   end

   assign div_out = div_ff;

endmodule

// ----- rtl/core/lco_div_step.sv -----
// ----------------------------------------------------------------------------
// lco_div_step
// one restoring division step, one quotient bit per register stage
// ----------------------------------------------------------------------------
module lco_div_step
   import lco_pkg::*;
(
   input  logic    clock,
   input  logic    enable,
   input  div_type div_in,
   output div_type div_out
);

   logic [TOT_W:0]   trial;
   logic [TOT_W+1:0] diff;
   logic             ge;
   div_type          step_ff;
   div_type          step_in;

   always_comb begin
      trial         = {div_in.rem, div_in.low[QUOT_W-1]};
      diff          = {1'b0, trial} - {2'b00, div_in.den};
      ge            = !diff[TOT_W+1];
      step_in       = div_in;
      step_in.rem   = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      step_in.low   = {div_in.low[QUOT_W-2:0], 1'b0};
      step_in.quot  = {div_in.quot[QUOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         step_ff <= step_in;
      end
   end

   assign div_out = step_ff;

endmodule

// ----- rtl/core/line_centroid_offset.sv -----
// ----------------------------------------------------------------------------
// line_centroid_offset
// darkness-weighted line position of an eight-channel reflectance frame
// ----------------------------------------------------------------------------
// one frame of eight levels comes in on the req_ channel, one result goes out
// on the rsp_ channel: rsp_offset, the weighted centroid truncated toward
// zero in -350..350, and rsp_all_white, set with a zero offset when the whole
// frame reads full scale
// an item is taken on a rising edge with valid high and stall low
// from the accepting edge the result passes the four front stages, the nine
// divider stages, then the output register before showing on rsp_, the
// first front stage loading on the accepting edge itself
// throughput: one item per cycle while req_stall is low, each divider stage yields one quotient bit
// req_stall rises only when every stage ahead of the input holds an item and
// the output register is stalled; empty stages close up behind a stalled
// result, so new items keep coming in until the pipe is full
// reset (synchronous, active high) empties every stage; the pipe holds no
// other state, so results never depend on earlier frames
// ----------------------------------------------------------------------------
`include "line_centroid_offset_assert.svh"

module line_centroid_offset
   import lco_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [LEVEL_W-1:0]         req_level_0,
   input  logic [LEVEL_W-1:0]         req_level_1,
   input  logic [LEVEL_W-1:0]         req_level_2,
   input  logic [LEVEL_W-1:0]         req_level_3,
   input  logic [LEVEL_W-1:0]         req_level_4,
   input  logic [LEVEL_W-1:0]         req_level_5,
   input  logic [LEVEL_W-1:0]         req_level_6,
   input  logic [LEVEL_W-1:0]         req_level_7,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OFFSET_W-1:0] rsp_offset,
   output logic                       rsp_all_white
);

   // per-stage occupancy and ready chain
   logic [PIPE_STAGES-1:0]    vld_ff;
   logic [PIPE_STAGES-1:0]    vld_in;
   logic [PIPE_STAGES-1:0]    vld_prev;
   logic [PIPE_STAGES:0]      rdy;

   level_type                 level [CHANNELS];
   div_type                   div_chain [DIV_STAGES+1];

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic signed [OFFSET_W-1:0] rsp_offset_ff;
   logic signed [OFFSET_W-1:0] rsp_offset_in;
   logic                      rsp_all_white_ff;
   logic                      rsp_all_white_in;
   logic [OFFSET_W-1:0]       quot_ext;

   assign level[0] = req_level_0;
   assign level[1] = req_level_1;
   assign level[2] = req_level_2;
   assign level[3] = req_level_3;
   assign level[4] = req_level_4;
   assign level[5] = req_level_5;
   assign level[6] = req_level_6;
   assign level[7] = req_level_7;

   // a stage may load when it is empty or its successor moves on
   assign rdy[PIPE_STAGES] = !rsp_valid_ff || !rsp_stall;

   for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_rdy
      assign rdy[k] = !vld_ff[k] || rdy[k + 1];
   end

   assign req_stall = !rdy[0];

   // valid bits move in step with the data registers
   assign vld_prev = {vld_ff[PIPE_STAGES-2:0], req_valid};

   always_comb begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_prev[k] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // darkness, sums and sign split
   lco_dark_sum u_dark_sum (
      .clock   (clock),
      .enable  (rdy[FRONT_STAGES-1:0]),
      .level   (level),
      .div_out (div_chain[0])
   );

   // divider, most significant quotient bit first
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      lco_div_step u_div_step (
         .clock   (clock),
         .enable  (rdy[FRONT_STAGES + g]),
         .div_in  (div_chain[g]),
         .div_out (div_chain[g + 1])
      );
   end

   // restore the sign, force zero for an all-white frame
   always_comb begin
      quot_ext         = OFFSET_W'(div_chain[DIV_STAGES].quot);
      rsp_all_white_in = div_chain[DIV_STAGES].white;
      if (div_chain[DIV_STAGES].white) begin
         rsp_offset_in = '0;
      end else if (div_chain[DIV_STAGES].neg) begin
         rsp_offset_in = -$signed(quot_ext);
      end else begin
         rsp_offset_in = $signed(quot_ext);
      end
      rsp_valid_in = rdy[PIPE_STAGES] ? vld_ff[PIPE_STAGES-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[PIPE_STAGES]) begin
         rsp_offset_ff    <= rsp_offset_in;
         rsp_all_white_ff <= rsp_all_white_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_offset    = rsp_offset_ff;
   assign rsp_all_white = rsp_all_white_ff;

   // an all-white result always carries a zero offset
   `LCO_ASSERT_NOW(a_white_zero, clock, reset, rsp_valid_ff && rsp_all_white_ff, rsp_offset_ff == '0)

   // the centroid never leaves the span of the outer weights
   `LCO_ASSERT_NOW(a_offset_span, clock, reset, rsp_valid_ff, (rsp_offset_ff <= OFFSET_LIMIT) && (rsp_offset_ff >= -OFFSET_LIMIT))

   // an empty output register means the whole pipe can advance
   `LCO_ASSERT_NOW(a_empty_no_stall, clock, reset, !rsp_valid_ff, !req_stall)

   // an accepted item is held in the first stage on the next cycle
   `LCO_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, vld_ff[0])

endmodule
